>>> sv/npgo_pkg.sv
// Package for the nearest point goal offset block.
// Holds widths, item and state types and the saturation helper.
// Used by every module of the block; depends on nothing.
package npgo_pkg;

  localparam int CW   = 24;
  localparam int MW   = CW + 1;
  localparam int DW   = 2 * MW + 1;
  localparam int AW   = (MW < 31) ? MW : 31;
  localparam int NB   = 2 * (AW + 1);
  localparam int GOW  = 16;
  localparam int OW   = GOW + 1;
  localparam int NW   = GOW + AW + 2;
  localparam int SUMW = (CW + 2 > OW + 2) ? CW + 2 : OW + 2;
  localparam int SQCW = $clog2(AW + 2);
  localparam int DVCW = $clog2(NW + 1);
  localparam logic [GOW-1:0] GOAL_OFFSET_RST = GOW'(2560);

  localparam logic [1:0] OP_POS   = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  typedef enum logic [1:0] {
    K_POS,
    K_POINT,
    K_LAST,
    K_END
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PDIFF,
    ST_PSQR,
    ST_PCMP,
    ST_EDIFF,
    ST_ESQR,
    ST_ESUM,
    ST_SQRT,
    ST_DMUL,
    ST_DLOAD,
    ST_DRUN,
    ST_GOAL,
    ST_EMIT
  } state_e;

  function automatic logic [CW-1:0] sat(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] hi;
    logic signed [SUMW-1:0] lo;
    hi = SUMW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    lo = -SUMW'(64'sd1 <<< (CW - 1));
    if (v > hi) begin
      return hi[CW-1:0];
    end else if (v < lo) begin
      return lo[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

endpackage

>>> sv/npgo_queue.sv
// Two-entry request queue between the front and back parts.
// Depends on npgo_pkg for the item type.
module npgo_queue import npgo_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t      mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule

>>> sv/npgo_front.sv
// Front part: accepts requests, classifies them and drops undefined codes.
// Depends on npgo_pkg and feeds the request queue.
module npgo_front import npgo_pkg::*; (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic signed [CW-1:0] coord_x_i,
  input  logic signed [CW-1:0] coord_y_i,
  input  logic                 last_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output item_t                item_o
);

  logic known;

  always_comb begin
    known       = 1'b1;
    item_o.x    = coord_x_i;
    item_o.y    = coord_y_i;
    item_o.kind = K_POS;
    case (op_i)
      OP_POS:   item_o.kind = K_POS;
      OP_POINT: item_o.kind = last_i ? K_LAST : K_POINT;
      OP_END:   item_o.kind = K_END;
      default:  known = 1'b0;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && known;

endmodule

>>> sv/npgo_back.sv
// Back part: distance search, square root and divider for the goal offset.
// Depends on npgo_pkg; takes requests from the queue and drives the result.
module npgo_back import npgo_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [GOW-1:0]       cfg_data_i,
  input  logic                 q_valid_i,
  input  item_t                q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [CW-1:0] goal_x_o,
  output logic signed [CW-1:0] goal_y_o,
  output logic                 status_o
);

  state_e state_q, state_d;

  logic [GOW-1:0]       goff_q;
  logic                 own_valid_q, started_q, out_valid_q, sel_y_q;
  logic signed [CW-1:0] own_x_q, own_y_q, best_x_q, best_y_q;
  logic [DW-1:0]        best_d_q;
  item_t                item_q;
  logic [MW-1:0]        mx_q, my_q;
  logic [AW-1:0]        ax_q, ay_q;
  logic                 negx_q, negy_q;
  logic [2*MW-1:0]      sqx_q, sqy_q;
  logic [NB-1:0]        n_q;
  logic [AW:0]          root_q;
  logic [AW+1:0]        rem_q;
  logic [SQCW-1:0]      sqcnt_q;
  logic [GOW+AW-1:0]    prod_q;
  logic [NW-1:0]        num_q;
  logic [AW+1:0]        r_q;
  logic [DVCW-1:0]      dvcnt_q;
  logic [OW-1:0]        offx_q, offy_q;
  logic [CW-1:0]        gx_q, gy_q, gout_x_q, gout_y_q;
  logic                 gst_q, st_out_q;

  logic signed [MW-1:0] pdx, pdy, edx, edy;
  logic [MW-1:0]        pmx, pmy, emx, emy;
  logic [DW-1:0]        psum;
  logic [AW+3:0]        rem_t, trial;
  logic [AW+2:0]        r_t, den;
  logic                 out_free;
  logic signed [SUMW-1:0] sgx, sgy;

  always_comb begin
    pdx = MW'(item_q.x) - MW'(own_x_q);
    pdy = MW'(item_q.y) - MW'(own_y_q);
    pmx = pdx[MW-1] ? MW'(-pdx) : MW'(pdx);
    pmy = pdy[MW-1] ? MW'(-pdy) : MW'(pdy);
    edx = MW'(best_x_q) - MW'(own_x_q);
    edy = MW'(best_y_q) - MW'(own_y_q);
    emx = edx[MW-1] ? MW'(-edx) : MW'(edx);
    emy = edy[MW-1] ? MW'(-edy) : MW'(edy);
    for (int k = 0; k < 2; k++) begin
      if ((emx >> 31) != '0 || (emy >> 31) != '0) begin
        emx = emx >> 1;
        emy = emy >> 1;
      end
    end
    psum  = DW'(sqx_q) + DW'(sqy_q);
    rem_t = {rem_q, n_q[NB-1 -: 2]};
    trial = (AW+4)'({root_q, 2'b01});
    den   = (AW+3)'({root_q, 1'b0});
    r_t   = {r_q, num_q[NW-1]};
    sgx   = SUMW'(best_x_q) + (negx_q ? -SUMW'(offx_q) : SUMW'(offx_q));
    sgy   = SUMW'(best_y_q) + (negy_q ? -SUMW'(offy_q) : SUMW'(offy_q));
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_item_i.kind)
            K_POS:   state_d = ST_IDLE;
            K_END:   state_d = ST_EDIFF;
            default: state_d = ST_PDIFF;
          endcase
        end
      end
      ST_PDIFF: state_d = ST_PSQR;
      ST_PSQR:  state_d = ST_PCMP;
      ST_PCMP:  state_d = (item_q.kind == K_LAST) ? ST_EDIFF : ST_IDLE;
      ST_EDIFF: begin
        if (!own_valid_q) begin
          state_d = ST_EMIT;
        end else if (emx == '0 && emy == '0) begin
          state_d = ST_GOAL;
        end else begin
          state_d = ST_ESQR;
        end
      end
      ST_ESQR:  state_d = ST_ESUM;
      ST_ESUM:  state_d = ST_SQRT;
      ST_SQRT:  state_d = (sqcnt_q == SQCW'(AW)) ? ST_DMUL : ST_SQRT;
      ST_DMUL:  state_d = ST_DLOAD;
      ST_DLOAD: state_d = ST_DRUN;
      ST_DRUN: begin
        if (dvcnt_q == DVCW'(NW - 1)) begin
          state_d = sel_y_q ? ST_GOAL : ST_DMUL;
        end
      end
      ST_GOAL:  state_d = ST_EMIT;
      ST_EMIT:  state_d = out_free ? ST_IDLE : ST_EMIT;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      goff_q      <= GOAL_OFFSET_RST;
      own_valid_q <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      own_x_q     <= '0;
      own_y_q     <= '0;
      best_x_q    <= '0;
      best_y_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        goff_q <= cfg_data_i;
      end
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_IDLE && q_valid_i && q_item_i.kind == K_POS) begin
        own_x_q     <= q_item_i.x;
        own_y_q     <= q_item_i.y;
        own_valid_q <= 1'b1;
      end
      if (state_q == ST_PCMP && (!started_q || psum < best_d_q)) begin
        best_x_q  <= item_q.x;
        best_y_q  <= item_q.y;
        started_q <= 1'b1;
      end
      if (state_q == ST_EMIT && out_free) begin
        best_x_q    <= '0;
        best_y_q    <= '0;
        started_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        item_q  <= q_item_i;
        sel_y_q <= 1'b0;
        gst_q   <= 1'b0;
      end
      ST_PDIFF: begin
        mx_q <= pmx;
        my_q <= pmy;
      end
      ST_PSQR: begin
        sqx_q <= mx_q * mx_q;
        sqy_q <= my_q * my_q;
      end
      ST_PCMP: begin
        if (!started_q || psum < best_d_q) begin
          best_d_q <= psum;
        end
      end
      ST_EDIFF: begin
        ax_q   <= emx[AW-1:0];
        ay_q   <= emy[AW-1:0];
        negx_q <= edx[MW-1];
        negy_q <= edy[MW-1];
        offx_q <= OW'(goff_q);
        offy_q <= '0;
        gx_q   <= '0;
        gy_q   <= '0;
        gst_q  <= !own_valid_q;
      end
      ST_ESQR: begin
        sqx_q <= (2*MW)'(ax_q * ax_q);
        sqy_q <= (2*MW)'(ay_q * ay_q);
      end
      ST_ESUM: begin
        n_q     <= NB'(psum);
        root_q  <= '0;
        rem_q   <= '0;
        sqcnt_q <= '0;
      end
      ST_SQRT: begin
        n_q     <= n_q << 2;
        sqcnt_q <= sqcnt_q + SQCW'(1);
        if (rem_t >= trial) begin
          rem_q  <= (AW+2)'(rem_t - trial);
          root_q <= {root_q[AW-1:0], 1'b1};
        end else begin
          rem_q  <= rem_t[AW+1:0];
          root_q <= {root_q[AW-1:0], 1'b0};
        end
      end
      ST_DMUL: begin
        prod_q <= goff_q * (sel_y_q ? ay_q : ax_q);
      end
      ST_DLOAD: begin
        num_q   <= NW'({prod_q, 1'b0}) + NW'(root_q);
        r_q     <= '0;
        dvcnt_q <= '0;
      end
      ST_DRUN: begin
        dvcnt_q <= dvcnt_q + DVCW'(1);
        if (r_t >= den) begin
          r_q   <= (AW+2)'(r_t - den);
          num_q <= {num_q[NW-2:0], 1'b1};
        end else begin
          r_q   <= r_t[AW+1:0];
          num_q <= {num_q[NW-2:0], 1'b0};
        end
        if (dvcnt_q == DVCW'(NW - 1)) begin
          sel_y_q <= 1'b1;
          if (sel_y_q) begin
            offy_q <= {num_q[OW-2:0], r_t >= den};
          end else begin
            offx_q <= {num_q[OW-2:0], r_t >= den};
          end
        end
      end
      ST_GOAL: begin
        gx_q <= sat(sgx);
        gy_q <= sat(sgy);
      end
      ST_EMIT: begin
        if (out_free) begin
          gout_x_q <= gx_q;
          gout_y_q <= gy_q;
          st_out_q <= gst_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign goal_x_o    = gout_x_q;
  assign goal_y_o    = gout_y_q;
  assign status_o    = st_out_q;

endmodule

>>> sv/nearest_point_goal_offset.sv
// Top level of the nearest point goal offset block.
// Depends on npgo_pkg, npgo_front, npgo_queue and npgo_back.
//
// Position and point requests go through a two-entry queue to a sequential
// back end. A position only updates the own position; a candidate point passes
// difference, squaring and compare in the back end. At the end of a list the
// goal needs a two-bit-per-cycle square root of the squared distance and a
// one-bit-per-cycle divider run once for each axis. Without an own position
// the goal skips these steps. The queue keeps taking requests meanwhile,
// until it is full.
module nearest_point_goal_offset import npgo_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [GOW-1:0]       cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           op_i,
  input  logic signed [CW-1:0] coord_x_i,
  input  logic signed [CW-1:0] coord_y_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [CW-1:0] goal_x_o,
  output logic signed [CW-1:0] goal_y_o,
  output logic                 status_o
);

  logic  q_full, push, q_valid, q_pop;
  item_t push_item, q_item;

  npgo_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .coord_x_i  (coord_x_i),
    .coord_y_i  (coord_y_i),
    .last_i     (last_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  npgo_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (q_item)
  );

  npgo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .goal_x_o    (goal_x_o),
    .goal_y_o    (goal_y_o),
    .status_o    (status_o)
  );

endmodule

>>> sim/tb_nearest_point_goal_offset.sv
// Testbench for nearest_point_goal_offset: directed and random request streams
// checked against a behavioral predictor of the nearest-point search and goal.
// Depends on npgo_pkg and the nearest_point_goal_offset RTL.
module tb_nearest_point_goal_offset;
  import npgo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;
  localparam longint CMAXV = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMINV = -(64'sd1 <<< (CW - 1));

  typedef struct {
    logic [CW-1:0] gx;
    logic [CW-1:0] gy;
    logic          status;
  } goal_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [GOW-1:0]       cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           op_i = OP_POS;
  logic signed [CW-1:0] coord_x_i = '0;
  logic signed [CW-1:0] coord_y_i = '0;
  logic                 last_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [CW-1:0] goal_x_o;
  logic signed [CW-1:0] goal_y_o;
  logic                 status_o;

  localparam logic [1:0] OP_BAD = 2'd3;

  goal_t  goal_q[$];
  int     errors = 0;
  int     cycles = 0;
  bit     idle_on = 1'b1;
  int     stall_left = 0;

  longint unsigned offset_m;
  longint own_x_m, own_y_m, best_x_m, best_y_m;
  bit     own_valid_m, started_m;
  bit [65:0] best_d_m;

  nearest_point_goal_offset dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_stall_o,
    .op_i, .coord_x_i, .coord_y_i, .last_i, .out_valid_o, .out_stall_i,
    .goal_x_o, .goal_y_o, .status_o
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("nearest_point_goal_offset test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!idle_on) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 18);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch at %0d: %s got %0h expected %0h", cycles, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    goal_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (goal_q.size() == 0) begin
        report("unexpected goal", goal_x_o, 0);
      end else begin
        e = goal_q.pop_front();
        if (goal_x_o !== e.gx) report("goal_x", goal_x_o, e.gx);
        if (goal_y_o !== e.gy) report("goal_y", goal_y_o, e.gy);
        if (status_o !== e.status) report("status", status_o, e.status);
      end
    end
  end

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic longint clamp_coord(input longint v);
    if (v > CMAXV) return CMAXV;
    if (v < CMINV) return CMINV;
    return v;
  endfunction

  function automatic longint push_axis(input longint unsigned a, input longint unsigned len,
                                       input longint d);
    longint unsigned q;
    q = (2 * offset_m * a + len) / (2 * len);
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic clear_search();
    best_x_m = 0;
    best_y_m = 0;
    best_d_m = '1;
    started_m = 1'b0;
  endtask

  task automatic finish_list();
    goal_t g;
    longint dx, dy, ox, oy;
    longint unsigned ax, ay, len;
    g.gx = '0;
    g.gy = '0;
    g.status = 1'b1;
    if (own_valid_m) begin
      dx = best_x_m - own_x_m;
      dy = best_y_m - own_y_m;
      if (dx == 0 && dy == 0) begin
        ox = offset_m;
        oy = 0;
      end else begin
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
          ax >>= 1;
          ay >>= 1;
        end
        len = root_floor(ax * ax + ay * ay);
        ox = push_axis(ax, len, dx);
        oy = push_axis(ay, len, dy);
      end
      g.gx = CW'(clamp_coord(best_x_m + ox));
      g.gy = CW'(clamp_coord(best_y_m + oy));
      g.status = 1'b0;
    end
    goal_q.push_back(g);
    clear_search();
  endtask

  task automatic predict_goal(input logic [1:0] op, input logic signed [CW-1:0] x,
                              input logic signed [CW-1:0] y, input logic last);
    longint px, py, ax, ay;
    bit [65:0] d;
    px = x;
    py = y;
    case (op)
      OP_POS: begin
        own_x_m = px;
        own_y_m = py;
        own_valid_m = 1'b1;
      end
      OP_POINT: begin
        ax = px - own_x_m;
        ay = py - own_y_m;
        d = 66'(ax * ax) + 66'(ay * ay);
        if (!started_m || d < best_d_m) begin
          best_x_m = px;
          best_y_m = py;
          best_d_m = d;
          started_m = 1'b1;
        end
        if (last) finish_list();
      end
      OP_END: finish_list();
      default: ;
    endcase
  endtask

  task automatic send(input logic [1:0] op, input logic signed [CW-1:0] x,
                      input logic signed [CW-1:0] y, input logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    coord_x_i <= x;
    coord_y_i <= y;
    last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    predict_goal(op, x, y, last);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (goal_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_offset(input logic [GOW-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    offset_m = v;
  endtask

  function automatic logic signed [CW-1:0] pick_coord(input longint base);
    case ($urandom_range(0, 5))
      0, 1: return CW'($urandom);
      2: return $urandom_range(0, 1) ? CW'(CMAXV) : CW'(CMINV);
      3: return CW'(base + $urandom_range(0, 8) - 4);
      default: return CW'(base + $urandom_range(0, 4000) - 2000);
    endcase
  endfunction

  task automatic test_no_position();
    send(OP_END, 0, 0, 1'b0);
    send(OP_POINT, 100, -100, 1'b1);
    send(OP_POINT, 5, 5, 1'b0);
    send(OP_END, 0, 0, 1'b1);
    send(OP_BAD, CW'(CMAXV), CW'(CMINV), 1'b1);
  endtask

  task automatic test_directed();
    send(OP_POS, 0, 0, 1'b1);
    send(OP_END, 0, 0, 1'b0);
    send(OP_POINT, 0, 0, 1'b1);
    send(OP_POINT, 300, 400, 1'b0);
    send(OP_POINT, -300, -400, 1'b0);
    send(OP_POINT, 400, -300, 1'b1);
    send(OP_POINT, -7, 3, 1'b0);
    send(OP_POS, -7, 3, 1'b0);
    send(OP_POINT, 1000, 1000, 1'b0);
    send(OP_END, 0, 0, 1'b0);
    send(OP_POS, CW'(CMINV), CW'(CMINV), 1'b0);
    send(OP_POINT, CW'(CMAXV), CW'(CMAXV), 1'b1);
    send(OP_POS, CW'(CMAXV), CW'(CMINV), 1'b0);
    send(OP_POINT, CW'(CMINV), CW'(CMAXV), 1'b1);
    send(OP_POS, CW'(CMAXV), CW'(CMAXV), 1'b0);
    send(OP_POINT, CW'(CMAXV) - 1, CW'(CMAXV), 1'b1);
    send(OP_BAD, 1, 1, 1'b0);
    send(OP_POINT, 1, 2, 1'b1);
  endtask

  task automatic test_random(input int n);
    int sent;
    int len;
    longint bx, by;
    sent = 0;
    while (sent < n) begin
      case ($urandom_range(0, 19))
        0: send(OP_BAD, pick_coord(0), pick_coord(0), 1'($urandom));
        1: begin
          send(OP_END, pick_coord(0), pick_coord(0), 1'($urandom));
          sent++;
        end
        default: begin
          bx = own_x_m;
          by = own_y_m;
          if ($urandom_range(0, 2) != 0) begin
            bx = longint'(pick_coord(bx));
            by = longint'(pick_coord(by));
            send(OP_POS, CW'(bx), CW'(by), 1'($urandom));
            sent++;
          end
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) begin
              send(OP_POS, pick_coord(bx), pick_coord(by), 1'($urandom));
              sent++;
            end
            send(OP_POINT, pick_coord(bx), pick_coord(by), i == len - 1);
            sent++;
          end
          if ($urandom_range(0, 9) == 0) begin
            send(OP_POINT, pick_coord(bx), pick_coord(by), 1'b0);
            send(OP_END, 0, 0, 1'b0);
            sent += 2;
          end
        end
      endcase
    end
  endtask

  initial begin
    offset_m = GOAL_OFFSET_RST;
    own_x_m = 0;
    own_y_m = 0;
    own_valid_m = 1'b0;
    clear_search();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_position();
    test_directed();
    write_offset(16'd0);
    test_directed();
    write_offset(16'hFFFF);
    test_directed();
    test_random(450);
    write_offset(16'd1);
    test_random(300);
    write_offset(16'($urandom));
    test_random(450);
    write_offset(GOAL_OFFSET_RST);
    idle_on = 1'b0;
    test_random(550);
    drain();
    if (errors == 0) begin
      $display("nearest_point_goal_offset test passed");
    end else begin
      $display("nearest_point_goal_offset test failed");
    end
    $finish;
  end

endmodule
